/* rtl/core/mwws_pkg.sv */
// ----------------------------------------------------------------------------
// Mutex with waiter stack package
// Shared sizes, beat types and codes for the mutex and its waiter stack cells.
// ----------------------------------------------------------------------------
package mwws_pkg;

  localparam int MaxTasks = 32;
  localparam int TidW     = 5;
  localparam int CntW     = $clog2(MaxTasks + 1);
  localparam int StatW    = 3;

  localparam logic KIND_LOCK   = 1'b0;
  localparam logic KIND_UNLOCK = 1'b1;

  typedef enum logic [StatW-1:0] {
    ST_GRANTED = 3'd0,
    ST_BLOCKED = 3'd1,
    ST_FREED   = 3'd2,
    ST_HANDED  = 3'd3,
    ST_IGNORED = 3'd4,
    ST_FULL    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    SH_HOLD = 2'd0,
    SH_PUSH = 2'd1,
    SH_POP  = 2'd2
  } shop_e;

  typedef struct packed {
    logic            kind;
    logic [TidW-1:0] task_id;
  } req_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [TidW-1:0]  woken_task;
  } rsp_t;

endpackage

/* rtl/core/mutex_with_waiter_stack.sv */
// ----------------------------------------------------------------------------
// Mutex with waiter stack
// Hardware mutex whose blocked requesters wait on a LIFO stack built from a
// row of shifting cells; the owner's unlock hands the mutex to the top waiter.
// ----------------------------------------------------------------------------
// Channel   | Handshake        | Beat
// request   | start_i, busy_o  | req_i  (kind, task_id)
// response  | done_o           | rsp_o  (status, woken_task)
//
// A request is taken in any cycle and its response is shown in the next cycle,
// for one cycle, so one request per cycle is sustained, since the owner, the
// fill count and the cell row are all updated as the request is taken.
// busy_o stays low. Reset needs no clearing pass.
// The receiver cannot stall, so nothing backs up.
// ----------------------------------------------------------------------------
module mutex_with_waiter_stack (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  mwws_pkg::req_t req_i,
  output logic           busy_o,
  output logic           done_o,
  output mwws_pkg::rsp_t rsp_o
);
  import mwws_pkg::*;

  logic            held_q, held_d;
  logic [TidW-1:0] owner_q, owner_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q;
  rsp_t            rsp_q, rsp_d;
  shop_e           op;
  logic            accept;

  logic [TidW-1:0] cell_q [MaxTasks];

  assign accept = start_i && !busy_o;

  always_comb begin
    held_d  = held_q;
    owner_d = owner_q;
    cnt_d   = cnt_q;
    op      = SH_HOLD;
    rsp_d.status     = ST_IGNORED;
    rsp_d.woken_task = '0;
    if (req_i.kind == KIND_LOCK) begin
      if (!held_q) begin
        held_d       = 1'b1;
        owner_d      = req_i.task_id;
        rsp_d.status = ST_GRANTED;
      end else if (cnt_q == CntW'(MaxTasks)) begin
        rsp_d.status = ST_FULL;
      end else begin
        cnt_d        = cnt_q + CntW'(1);
        op           = SH_PUSH;
        rsp_d.status = ST_BLOCKED;
      end
    end else begin
      if (!held_q || owner_q != req_i.task_id) begin
        rsp_d.status = ST_IGNORED;
      end else if (cnt_q != '0) begin
        cnt_d            = cnt_q - CntW'(1);
        op               = SH_POP;
        owner_d          = cell_q[0];
        rsp_d.woken_task = cell_q[0];
        rsp_d.status     = ST_HANDED;
      end else begin
        held_d       = 1'b0;
        owner_d      = '0;
        cnt_d        = '0;
        rsp_d.status = ST_FREED;
      end
    end
    if (!accept) begin
      held_d  = held_q;
      owner_d = owner_q;
      cnt_d   = cnt_q;
      op      = SH_HOLD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      owner_q <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      held_q  <= held_d;
      owner_q <= owner_d;
      cnt_q   <= cnt_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  for (genvar i = 0; i < MaxTasks; i++) begin : g_cell
    logic [TidW-1:0] up, dn;
    if (i == 0) begin : g_top
      assign up = req_i.task_id;
    end else begin : g_mid
      assign up = cell_q[i-1];
    end
    if (i == MaxTasks - 1) begin : g_bot
      assign dn = '0;
    end else begin : g_inner
      assign dn = cell_q[i+1];
    end
    mwws_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .op_i   (op),
      .up_i   (up),
      .dn_i   (dn),
      .q_o    (cell_q[i])
    );
  end

  assign busy_o = 1'b0;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

/* rtl/core/mwws_cell.sv */
// ----------------------------------------------------------------------------
// Waiter stack cell
// One entry of the shifting waiter stack; takes its upper neighbor's entry on
// a push and its lower neighbor's entry on a pop.
// ----------------------------------------------------------------------------
module mwws_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mwws_pkg::shop_e       op_i,
  input  logic [mwws_pkg::TidW-1:0] up_i,
  input  logic [mwws_pkg::TidW-1:0] dn_i,
  output logic [mwws_pkg::TidW-1:0] q_o
);
  import mwws_pkg::*;

  logic [TidW-1:0] entry_q, entry_d;

  always_comb begin
    case (op_i)
      SH_PUSH: entry_d = up_i;
      SH_POP:  entry_d = dn_i;
      default: entry_d = entry_q;
    endcase
  end

  // The stack fill count alone tells which entries are valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign q_o = entry_q;

endmodule

/* rtl/core/mwws_checker.sv */
// ----------------------------------------------------------------------------
// Mutex with waiter stack checker
// Port-level checks of the request and response timing, the response codes and the woken task field.
// ----------------------------------------------------------------------------
module mwws_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input mwws_pkg::req_t req_i,
  input logic           busy_o,
  input logic           done_o,
  input mwws_pkg::rsp_t rsp_o
);
  import mwws_pkg::*;

  a_resp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("Accepted request gave no response beat.");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> !done_o)
    else $error("Response beat without a request.");

  a_woken_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != ST_HANDED) |-> rsp_o.woken_task == '0)
    else $error("Woken task set on a response that hands nothing over.");

  a_lock_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status == ST_GRANTED || rsp_o.status == ST_BLOCKED ||
     rsp_o.status == ST_FULL)) |-> $past(req_i.kind) == KIND_LOCK)
    else $error("Lock response code for an unlock request.");

  a_unlock_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.status == ST_FREED || rsp_o.status == ST_HANDED ||
     rsp_o.status == ST_IGNORED)) |-> $past(req_i.kind) == KIND_UNLOCK)
    else $error("Unlock response code for a lock request.");

endmodule

bind mutex_with_waiter_stack mwws_checker u_mwws_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .req_i   (req_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .rsp_o   (rsp_o)
);
